[hw/rtl/kht_pkg.sv]
// Shared constants, codes and default parameters of the keyed handle table.
package kht_pkg;

	// Fixed field widths of the request and response beats
	localparam int OPCODE_W     = 3;
	localparam int STATUS_W     = 3;
	localparam int SLOT_W       = 6;
	localparam int COUNT_OUT_W  = 7;
	localparam int CAP_W        = 7;
	localparam int OUT_HANDLE_W = 32;

	// Default sizing of the table
	localparam int DEF_TABLE_DEPTH = 64;
	localparam int DEF_KEY_BITS    = 16;
	localparam int DEF_HANDLE_BITS = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	// Opcodes
	localparam logic [OPCODE_W-1:0] OP_ADD    = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_RM_KEY = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_RM_IDX = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_FIND   = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_GET    = 3'd4;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_LIMIT     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

endpackage

[hw/rtl/kht_req_if.sv]
// Request channel of the keyed handle table: valid/ready plus one operation.
interface kht_req_if #(
	parameter int KEY_BITS    = kht_pkg::DEF_KEY_BITS,
	parameter int HANDLE_BITS = kht_pkg::DEF_HANDLE_BITS
);
	import kht_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [OPCODE_W-1:0]        opcode;
	logic signed [KEY_BITS-1:0] key;
	logic [HANDLE_BITS-1:0]     handle;
	logic [SLOT_W-1:0]          slot_index;

	modport source (output valid, opcode, key, handle, slot_index, input ready);
	modport sink   (input valid, opcode, key, handle, slot_index, output ready);
endinterface

[hw/rtl/kht_rsp_if.sv]
// Response channel of the keyed handle table: valid/ready plus one result.
interface kht_rsp_if;
	import kht_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [STATUS_W-1:0]     status;
	logic [OUT_HANDLE_W-1:0] found_handle;
	logic [SLOT_W-1:0]       found_index;
	logic [OUT_HANDLE_W-1:0] released_handle;
	logic [COUNT_OUT_W-1:0]  entry_count;

	modport source (output valid, status, found_handle, found_index, released_handle,
		entry_count, input ready);
	modport sink   (input valid, status, found_handle, found_index, released_handle,
		entry_count, output ready);
endinterface

[hw/rtl/kht_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module kht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[hw/rtl/keyed_handle_table_core.sv]
// Keyed handle table: dense key/handle store with swap-last delete, one RAM.
//
//  channel   dir  width                  beat carries
//  req       in   3+KEY+HANDLE+6         opcode, key, handle, slot_index
//  rsp       out  3+32+6+32+7            status, found_handle, found_index,
//                                        released_handle, entry_count
//  cfg       in   7                      capacity_limit (cfg_we, cfg_wdata)
//
// Flow: one operation at a time. Get and remove-at-index check the index and
// read that slot directly. Add, find and remove-by-key walk the key RAM one
// entry per cycle from position 0. A remove of either kind then moves the last
// entry into the hole. The single RAM read port forces the walk.
// Reset: arst_n clears the entry count and loads capacity_limit with 64; the
// RAM is not cleared, since only positions below the count are ever used.
// Stalls: a finished result waits in the response register; the next request
// beat is taken meanwhile and only its own completion waits for rsp.ready.
module keyed_handle_table_core #(
	parameter int TABLE_DEPTH = kht_pkg::DEF_TABLE_DEPTH,
	parameter int KEY_BITS    = kht_pkg::DEF_KEY_BITS,
	parameter int HANDLE_BITS = kht_pkg::DEF_HANDLE_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [kht_pkg::CAP_W-1:0] cfg_wdata,
	kht_req_if.sink                  req,
	kht_rsp_if.source                rsp
);
	import kht_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int LW = (CW > CAP_W) ? CW : CAP_W;
	localparam int IW = (CW > SLOT_W) ? CW : SLOT_W;
	localparam int EW = KEY_BITS + HANDLE_BITS;

	// Only the low 32 bits of a request handle are stored
	localparam logic [HANDLE_BITS-1:0] HIN_MASK = (HANDLE_BITS > OUT_HANDLE_W) ?
		HANDLE_BITS'({OUT_HANDLE_W{1'b1}}) : {HANDLE_BITS{1'b1}};

	// Sequencer states
	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_CHECK    = 3'd1;
	localparam logic [2:0] S_SRCH     = 3'd2;
	localparam logic [2:0] S_IDX_WAIT = 3'd3;
	localparam logic [2:0] S_MOVE_RD  = 3'd4;
	localparam logic [2:0] S_MOVE_WR  = 3'd5;
	localparam logic [2:0] S_DONE     = 3'd6;

	logic [2:0]  state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CAP_W-1:0] cap_q;

	// Latched request
	logic [OPCODE_W-1:0]    op_q;
	logic [KEY_BITS-1:0]    key_q;
	logic [HANDLE_BITS-1:0] hnd_q;
	logic [SLOT_W-1:0]      idx_q;

	// Search walk: issue pointer and the compare stage registered behind it
	logic [CW-1:0] issue_ptr_q;
	logic          rd_pend_s1;
	logic [CW-1:0] ptr_s1;
	logic          issue;

	// Result under construction
	logic [STATUS_W-1:0]     st_q, st_d;
	logic [OUT_HANDLE_W-1:0] fh_q, fh_d;
	logic [SLOT_W-1:0]       fi_q, fi_d;
	logic [OUT_HANDLE_W-1:0] rh_q, rh_d;
	logic [AW-1:0]           pos_q, pos_d;
	logic                    load_rsp;

	// Response register
	logic                    rsp_valid_q;
	logic [STATUS_W-1:0]     rsp_status_q;
	logic [OUT_HANDLE_W-1:0] rsp_fh_q;
	logic [SLOT_W-1:0]       rsp_fi_q;
	logic [OUT_HANDLE_W-1:0] rsp_rh_q;
	logic [COUNT_OUT_W-1:0]  rsp_cnt_q;

	// RAM port
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [EW-1:0] ram_rdata;

	logic [KEY_BITS-1:0]    rkey;
	logic [HANDLE_BITS-1:0] rhnd;
	logic accept;
	logic key_neg;
	logic hnd_zero;
	logic idx_bad;
	logic limit_hit;
	logic issue_done;
	logic match;

	kht_ram #(
		.WIDTH (EW),
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rkey = ram_rdata[EW-1:HANDLE_BITS];
	assign rhnd = ram_rdata[HANDLE_BITS-1:0];

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;

	assign key_neg    = key_q[KEY_BITS-1];
	assign hnd_zero   = (hnd_q == '0);
	assign idx_bad    = IW'(idx_q) >= IW'(count_q);
	// count >= min(capacity_limit, TABLE_DEPTH)
	assign limit_hit  = (LW'(count_q) >= LW'(cap_q)) || (count_q == CW'(TABLE_DEPTH));
	assign issue_done = (issue_ptr_q >= count_q);
	assign match      = rd_pend_s1 && (rkey == key_q);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		st_d      = st_q;
		fh_d      = fh_q;
		fi_d      = fi_q;
		rh_d      = rh_q;
		pos_d     = pos_q;
		issue     = 1'b0;
		load_rsp  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = {key_q, hnd_q};
		ram_raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					st_d    = ST_OK;
					fh_d    = '0;
					fi_d    = '0;
					rh_d    = '0;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				case (op_q)
					OP_ADD: begin
						if (key_neg || hnd_zero) begin
							st_d    = ST_INVALID;
							state_d = S_DONE;
						end else begin
							state_d = S_SRCH;
						end
					end
					OP_RM_KEY, OP_FIND: begin
						if (key_neg) begin
							st_d    = ST_INVALID;
							state_d = S_DONE;
						end else begin
							state_d = S_SRCH;
						end
					end
					OP_RM_IDX, OP_GET: begin
						if (idx_bad) begin
							st_d    = ST_NOT_FOUND;
							state_d = S_DONE;
						end else begin
							ram_raddr = AW'(idx_q);
							state_d   = S_IDX_WAIT;
						end
					end
					default: begin
						st_d    = ST_INVALID;
						state_d = S_DONE;
					end
				endcase
			end
			S_SRCH: begin
				// Issue one read a cycle; compare the entry read last cycle
				ram_raddr = issue_ptr_q[AW-1:0];
				issue     = !issue_done;
				if (match) begin
					case (op_q)
						OP_ADD: begin
							st_d    = ST_DUPLICATE;
							state_d = S_DONE;
						end
						OP_RM_KEY: begin
							rh_d    = OUT_HANDLE_W'(rhnd);
							pos_d   = ptr_s1[AW-1:0];
							state_d = S_MOVE_RD;
						end
						default: begin
							fh_d    = OUT_HANDLE_W'(rhnd);
							fi_d    = SLOT_W'(ptr_s1);
							state_d = S_DONE;
						end
					endcase
				end else if (issue_done) begin
					if (op_q == OP_ADD) begin
						if (limit_hit) begin
							st_d = ST_LIMIT;
						end else begin
							// Append at the end
							ram_we    = 1'b1;
							ram_waddr = AW'(count_q);
							count_d   = count_q + CW'(1);
						end
					end else begin
						st_d = ST_NOT_FOUND;
					end
					state_d = S_DONE;
				end
			end
			S_IDX_WAIT: begin
				if (op_q == OP_GET) begin
					fh_d    = OUT_HANDLE_W'(rhnd);
					state_d = S_DONE;
				end else begin
					rh_d    = OUT_HANDLE_W'(rhnd);
					pos_d   = AW'(idx_q);
					state_d = S_MOVE_RD;
				end
			end
			S_MOVE_RD: begin
				ram_raddr = AW'(count_q - CW'(1));
				state_d   = S_MOVE_WR;
			end
			S_MOVE_WR: begin
				// Move the last entry into the hole and shrink
				ram_we    = 1'b1;
				ram_waddr = pos_q;
				ram_wdata = ram_rdata;
				count_d   = count_q - CW'(1);
				state_d   = S_DONE;
			end
			S_DONE: begin
				// Hold until the response register is free
				if (!rsp_valid_q || rsp.ready) begin
					load_rsp = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			cap_q       <= CAP_RESET;
			rsp_valid_q <= 1'b0;
			rd_pend_s1  <= 1'b0;
			issue_ptr_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			rd_pend_s1 <= (state_q == S_SRCH) && issue;
			if (state_q == S_CHECK) begin
				issue_ptr_q <= '0;
			end else if (issue) begin
				issue_ptr_q <= issue_ptr_q + CW'(1);
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req.opcode;
			key_q <= req.key;
			hnd_q <= req.handle & HIN_MASK;
			idx_q <= req.slot_index;
		end
		ptr_s1 <= issue_ptr_q;
		st_q   <= st_d;
		fh_q   <= fh_d;
		fi_q   <= fi_d;
		rh_q   <= rh_d;
		pos_q  <= pos_d;
		if (load_rsp) begin
			rsp_status_q <= st_q;
			rsp_fh_q     <= fh_q;
			rsp_fi_q     <= fi_q;
			rsp_rh_q     <= rh_q;
			rsp_cnt_q    <= COUNT_OUT_W'(count_q);
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = rsp_status_q;
	assign rsp.found_handle    = rsp_fh_q;
	assign rsp.found_index     = rsp_fi_q;
	assign rsp.released_handle = rsp_rh_q;
	assign rsp.entry_count     = rsp_cnt_q;
endmodule

[tb/keyed_handle_table_core_test.sv]
// Self-checking testbench of the keyed handle table core: directed and random operations.
`timescale 1ns / 100ps

module keyed_handle_table_core_test;
	import kht_pkg::*;

	localparam int DEPTH = DEF_TABLE_DEPTH;

	// One response beat as the table should produce it
	typedef struct packed {
		logic [STATUS_W-1:0]     status;
		logic [OUT_HANDLE_W-1:0] found_handle;
		logic [SLOT_W-1:0]       found_index;
		logic [OUT_HANDLE_W-1:0] released_handle;
		logic [COUNT_OUT_W-1:0]  entry_count;
	} table_result_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;

	kht_req_if req_bus ();
	kht_rsp_if rsp_bus ();

	keyed_handle_table_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_bus),
		.rsp       (rsp_bus)
	);

	// Shadow copy of the table contents and its limit register
	logic [DEF_KEY_BITS-1:0]    shadow_keys [DEPTH];
	logic [DEF_HANDLE_BITS-1:0] shadow_handles [DEPTH];
	int                         table_count;
	logic [CAP_W-1:0]           capacity_reg;

	table_result_t pending_results [$];
	int            mismatch_count;
	int            hold_request;   // cycles of response hold-off asked by a test
	bit            steady;         // set for the final stretch: no idling on either side

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Give up well past the slowest legal run
	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

	// ---------------------------------------------------------------- prediction

	// Search valid entries from position 0 upward; -1 when absent
	function automatic int locate_key(logic [DEF_KEY_BITS-1:0] k);
		for (int i = 0; i < table_count; i++) begin
			if (shadow_keys[i] == k)
				return i;
		end
		return -1;
	endfunction

	// Remove one entry: the last entry moves into the hole
	function automatic logic [DEF_HANDLE_BITS-1:0] evict_entry(int pos);
		logic [DEF_HANDLE_BITS-1:0] h;
		h = shadow_handles[pos];
		shadow_keys[pos]    = shadow_keys[table_count-1];
		shadow_handles[pos] = shadow_handles[table_count-1];
		table_count--;
		return h;
	endfunction

	// Apply one accepted request beat to the shadow table and queue its result
	function automatic void apply_request(logic [OPCODE_W-1:0] op, logic [DEF_KEY_BITS-1:0] k,
			logic [DEF_HANDLE_BITS-1:0] h, logic [SLOT_W-1:0] idx);
		table_result_t r;
		int            limit;
		int            pos;
		r = '0;
		r.status = ST_OK;
		// Saturate the limit register to the table depth
		limit = (capacity_reg > DEPTH) ? DEPTH : int'(capacity_reg);
		case (op)
			OP_ADD: begin
				if (k[DEF_KEY_BITS-1] || h == '0)
					r.status = ST_INVALID;
				else if (locate_key(k) >= 0)
					r.status = ST_DUPLICATE;
				else if (table_count >= limit)
					r.status = ST_LIMIT;
				else begin
					shadow_keys[table_count]    = k;
					shadow_handles[table_count] = h;
					table_count++;
				end
			end
			OP_RM_KEY: begin
				pos = locate_key(k);
				if (k[DEF_KEY_BITS-1])
					r.status = ST_INVALID;
				else if (pos < 0)
					r.status = ST_NOT_FOUND;
				else
					r.released_handle = evict_entry(pos);
			end
			OP_RM_IDX: begin
				if (int'(idx) >= table_count)
					r.status = ST_NOT_FOUND;
				else
					r.released_handle = evict_entry(int'(idx));
			end
			OP_FIND: begin
				pos = locate_key(k);
				if (k[DEF_KEY_BITS-1])
					r.status = ST_INVALID;
				else if (pos < 0)
					r.status = ST_NOT_FOUND;
				else begin
					r.found_handle = shadow_handles[pos];
					r.found_index  = SLOT_W'(pos);
				end
			end
			OP_GET: begin
				if (int'(idx) >= table_count)
					r.status = ST_NOT_FOUND;
				else
					r.found_handle = shadow_handles[idx];
			end
			default: r.status = ST_INVALID;
		endcase
		r.entry_count = COUNT_OUT_W'(table_count);
		pending_results.push_back(r);
	endfunction

	// ---------------------------------------------------------------- request side

	// Offer one request beat; optionally idle first. Called at a rising edge.
	task automatic send_op(logic [OPCODE_W-1:0] op, logic [DEF_KEY_BITS-1:0] k,
			logic [DEF_HANDLE_BITS-1:0] h, logic [SLOT_W-1:0] idx);
		if (!steady && $urandom_range(0, 7) == 0) begin
			req_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		req_bus.valid      <= 1'b1;
		req_bus.opcode     <= op;
		req_bus.key        <= k;
		req_bus.handle     <= h;
		req_bus.slot_index <= idx;
		// Hold the beat until the table takes it
		do
			@(posedge clk);
		while (!(req_bus.valid && req_bus.ready));
		apply_request(op, k, h, idx);
	endtask

	// Drop valid and wait until every queued result has come back
	task automatic wait_idle();
		req_bus.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Write the limit register while the table has nothing in flight
	task automatic set_capacity(logic [CAP_W-1:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we       <= 1'b0;
		capacity_reg  = value;
	endtask

	// ---------------------------------------------------------------- random fields

	// Mostly a small key set so that duplicates and hits happen; sometimes a stored key
	function automatic logic [DEF_KEY_BITS-1:0] draw_key(bit prefer_stored);
		int roll;
		roll = $urandom_range(0, 99);
		if (prefer_stored && table_count > 0 && roll < 60)
			return shadow_keys[$urandom_range(0, table_count - 1)];
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return DEF_KEY_BITS'($urandom_range(0, 23));
		if (roll < 90)
			return DEF_KEY_BITS'($urandom_range(0, 32767));
		return {1'b1, 15'($urandom)};
	endfunction

	function automatic logic [DEF_HANDLE_BITS-1:0] draw_handle();
		logic [DEF_HANDLE_BITS-1:0] h;
		if ($urandom_range(0, 19) == 0)
			return '0;
		do
			h = $urandom;
		while (h == '0);
		return h;
	endfunction

	function automatic logic [SLOT_W-1:0] draw_slot();
		if (table_count > 0 && $urandom_range(0, 4) != 0)
			return SLOT_W'($urandom_range(0, table_count - 1));
		return SLOT_W'($urandom_range(0, DEPTH - 1));
	endfunction

	// One random operation, weighted toward adds and lookups
	task automatic send_random_op();
		int              roll;
		logic [OPCODE_W-1:0] op;
		roll = $urandom_range(0, 99);
		if (roll < 35)
			op = OP_ADD;
		else if (roll < 50)
			op = OP_RM_KEY;
		else if (roll < 62)
			op = OP_RM_IDX;
		else if (roll < 80)
			op = OP_FIND;
		else if (roll < 97)
			op = OP_GET;
		else
			op = OPCODE_W'($urandom_range(5, 7));
		send_op(op, draw_key(op != OP_ADD), draw_handle(), draw_slot());
	endtask

	// ---------------------------------------------------------------- tests

	// Every opcode, the field extremes, swap-last moves and the invalid, duplicate and not-found statuses
	task automatic test_basic_ops();
		send_op(OP_FIND, 16'sd7, '0, '0);
		send_op(OP_GET, '0, '0, '0);
		send_op(OP_RM_IDX, '0, '0, 6'd63);
		send_op(OP_RM_KEY, '0, '0, '0);
		send_op(OP_ADD, 16'sd0, 32'd1, '0);
		send_op(OP_ADD, 16'sd32767, 32'hFFFF_FFFF, '0);
		send_op(OP_ADD, -16'sd32768, 32'd5, '0);        // negative key
		send_op(OP_ADD, 16'sd5, 32'd0, '0);             // null handle
		send_op(OP_ADD, 16'sd0, 32'd7, '0);             // key already stored
		send_op(OP_FIND, 16'sd32767, '0, '0);
		send_op(OP_FIND, -16'sd1, '0, '0);
		send_op(OP_RM_KEY, -16'sd5, '0, '0);
		send_op(OP_GET, '0, '0, 6'd1);
		send_op(OP_GET, '0, '0, 6'd63);
		send_op(3'd5, 16'sd1, 32'd1, 6'd0);             // undefined opcodes
		send_op(3'd6, -16'sd1, 32'hFFFF_FFFF, 6'd63);
		send_op(3'd7, 16'sd0, 32'd0, 6'd0);
		send_op(OP_ADD, 16'sd100, 32'h1234_5678, '0);
		send_op(OP_RM_KEY, 16'sd0, '0, '0);             // last entry moves to slot 0
		send_op(OP_FIND, 16'sd100, '0, '0);
		send_op(OP_RM_IDX, '0, '0, 6'd1);               // remove the last entry itself
		send_op(OP_RM_KEY, 16'sd999, '0, '0);
		send_op(OP_RM_IDX, '0, '0, 6'd0);
	endtask

	// Limit of one, zero, and a value above the depth that saturates
	task automatic test_capacity_limits();
		set_capacity(7'd1);
		send_op(OP_ADD, 16'sd1, 32'd11, '0);
		send_op(OP_ADD, 16'sd2, 32'd22, '0);            // full
		send_op(OP_ADD, 16'sd1, 32'd33, '0);            // duplicate wins over full
		send_op(OP_ADD, -16'sd1, 32'd0, '0);            // invalid wins over full
		set_capacity(7'd0);
		send_op(OP_RM_IDX, '0, '0, 6'd0);
		send_op(OP_ADD, 16'sd4, 32'd44, '0);
		set_capacity(7'd127);
		for (int i = 0; i < DEPTH; i++)
			send_op(OP_ADD, 16'(i * 509), $urandom | 32'd1, '0);
		send_op(OP_ADD, 16'sd1, 32'd1, '0);             // table full at the depth
		send_op(OP_GET, '0, '0, 6'd63);
		send_op(OP_FIND, 16'(63 * 509), '0, '0);
		send_op(OP_RM_IDX, '0, '0, 6'd63);
		send_op(OP_RM_KEY, 16'sd0, '0, '0);
		while (table_count > 0)
			send_op(OP_RM_IDX, '0, '0, SLOT_W'($urandom_range(0, table_count - 1)));
	endtask

	// Random traffic over several limit settings
	task automatic test_random_traffic();
		logic [CAP_W-1:0] caps [7];
		caps = '{7'd64, 7'd6, 7'd1, CAP_W'($urandom_range(2, 63)), 7'd127, 7'd0, 7'd64};
		foreach (caps[p]) begin
			set_capacity(caps[p]);
			repeat (26) send_random_op();
		end
	endtask

	// Hold off the response side long enough that the table stalls its input
	task automatic test_backpressure();
		wait_idle();
		hold_request = 400;
		repeat (15) send_random_op();
	endtask

	// Back-to-back beats with no idling on either side
	task automatic test_steady_stream();
		wait_idle();
		steady = 1'b1;
		repeat (40) send_random_op();
	endtask

	// ---------------------------------------------------------------- response side

	// Drive rsp.ready: a requested long hold first, else random stall bursts
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		rsp_bus.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_bus.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_bus.ready <= 1'b0;
			end else if (!steady && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 15) - 1;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= 1'b1;
			end
		end
	end

	task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0h actual %0h", $time, what, want, got);
			mismatch_count++;
		end
	endtask

	// Compare every response beat with the oldest pending result
	initial begin
		table_result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected response beat: expected none actual status %0h",
						$time, rsp_bus.status);
					mismatch_count++;
				end else begin
					want = pending_results.pop_front();
					check_field("status", 32'(want.status), 32'(rsp_bus.status));
					check_field("found_handle", want.found_handle, rsp_bus.found_handle);
					check_field("found_index", 32'(want.found_index),
						32'(rsp_bus.found_index));
					check_field("released_handle", want.released_handle,
						rsp_bus.released_handle);
					check_field("entry_count", 32'(want.entry_count),
						32'(rsp_bus.entry_count));
				end
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		mismatch_count = 0;
		hold_request   = 0;
		steady         = 1'b0;
		table_count    = 0;
		capacity_reg   = CAP_RESET;
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_wdata          <= '0;
		req_bus.valid      <= 1'b0;
		req_bus.opcode     <= '0;
		req_bus.key        <= '0;
		req_bus.handle     <= '0;
		req_bus.slot_index <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		test_capacity_limits();
		test_random_traffic();
		test_backpressure();
		test_steady_stream();

		// Drain, then give stray beats time to show up
		wait_idle();
		repeat (DEPTH + 8) @(posedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/kht_pkg.sv
hw/rtl/kht_req_if.sv
hw/rtl/kht_rsp_if.sv
hw/rtl/kht_ram.sv
hw/rtl/keyed_handle_table_core.sv
tb/keyed_handle_table_core_test.sv
